// ===== rtl/core/rbi_pkg.sv =====
// Shared constants, codes and helpers for the rigid body integrator.
// No dependencies; the top level refers to it by scoped names.
`default_nettype none

package rbi_pkg;

    // item modes
    localparam logic [2:0] MODE_IMPULSE = 3'd0;
    localparam logic [2:0] MODE_FORCE   = 3'd1;
    localparam logic [2:0] MODE_INTEG   = 3'd2;
    localparam logic [2:0] MODE_SET_XF  = 3'd3;
    localparam logic [2:0] MODE_SET_ORI = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_DYN  = 3'd0;
    localparam logic [2:0] CFG_IMAS = 3'd1;
    localparam logic [2:0] CFG_IIX  = 3'd2;
    localparam logic [2:0] CFG_IIY  = 3'd3;
    localparam logic [2:0] CFG_IIZ  = 3'd4;
    localparam logic [2:0] CFG_FRIC = 3'd5;
    localparam logic [2:0] CFG_TS   = 3'd6;

    // sequencer phases
    localparam logic [3:0] PH_IDLE = 4'd0;
    localparam logic [3:0] PH_CRS  = 4'd1;
    localparam logic [3:0] PH_IMP  = 4'd2;
    localparam logic [3:0] PH_TRQ  = 4'd3;
    localparam logic [3:0] PH_LIN  = 4'd4;
    localparam logic [3:0] PH_SSQ  = 4'd5;
    localparam logic [3:0] PH_CHK  = 4'd6;
    localparam logic [3:0] PH_DRV  = 4'd7;
    localparam logic [3:0] PH_DQ   = 4'd8;
    localparam logic [3:0] PH_NSQ  = 4'd9;
    localparam logic [3:0] PH_SQRT = 4'd10;
    localparam logic [3:0] PH_DIV  = 4'd11;
    localparam logic [3:0] PH_FRC  = 4'd12;
    localparam logic [3:0] PH_DMP  = 4'd13;
    localparam logic [3:0] PH_FIN  = 4'd14;

    // 1.0 in Q2.30
    localparam logic signed [31:0] QUAT_ONE = 32'sh4000_0000;

    typedef logic signed [31:0] t_word;

    // saturate a wide signed value to 32 bits
    function automatic t_word sat32(input logic signed [71:0] v);
        t_word res;
        if (v > 72'sd2147483647) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -72'sd2147483648) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rigid_body_integrator.sv =====
// Rigid body integrator: one shared 33x33 multiplier, a bit-serial root and
// a restoring divider under a phase sequencer. Uses rbi_pkg.
// Set transform/orientation and ignored items go straight to the final phase;
// an integrate whose spin is large enough to rotate is the longest item, as its
// 32-step root and four divides dominate.
// One item at a time; the next is taken once the sequencer is idle, while the
// previous result may still wait in the output register.
// Reset (synchronous, active low): zero motion, identity orientation, default config.
`default_nettype none

module rigid_body_integrator #(
    parameter int FRAC_BITS = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire  [2:0]          i_cfg_idx,
    input  wire  [30:0]         i_cfg_data,
    input  wire                 i_valid,
    output logic                o_stall,
    input  wire  [2:0]          i_mode,
    input  wire  signed [31:0]  i_vec_a_x,
    input  wire  signed [31:0]  i_vec_a_y,
    input  wire  signed [31:0]  i_vec_a_z,
    input  wire  signed [31:0]  i_vec_b_x,
    input  wire  signed [31:0]  i_vec_b_y,
    input  wire  signed [31:0]  i_vec_b_z,
    input  wire  signed [31:0]  i_quat_w,
    input  wire                 i_on_ground,
    output logic                o_valid,
    input  wire                 i_stall,
    output logic signed [31:0]  o_pos_x,
    output logic signed [31:0]  o_pos_y,
    output logic signed [31:0]  o_pos_z,
    output logic signed [31:0]  o_orient_x,
    output logic signed [31:0]  o_orient_y,
    output logic signed [31:0]  o_orient_z,
    output logic signed [31:0]  o_orient_w,
    output logic signed [31:0]  o_vel_x,
    output logic signed [31:0]  o_vel_y,
    output logic signed [31:0]  o_vel_z
);

    localparam logic [30:0] ONE_U    = 31'(64'd1 << FRAC_BITS);
    localparam logic [16:0] FRIC_RST = 17'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
    localparam logic [16:0] TS_RST   = 17'((64'd1 << FRAC_BITS) / 64'd60);
    localparam logic signed [32:0] DAMP =
        33'((((64'd98) << FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic [63:0] SPIN_EPS = 64'((65'd1 << (2 * FRAC_BITS)) / 65'd1000000);
    localparam logic signed [66:0] DQ_LIM = 67'sd1 <<< 45;
    localparam logic signed [66:0] ONE_S  = 67'sd1 <<< FRAC_BITS;

    // configuration
    logic        r_dyn;
    logic [30:0] r_imas;
    logic [30:0] r_iinv [3];
    logic [16:0] r_fric;
    logic [16:0] r_ts;

    // body state
    logic signed [31:0] r_pos [3];
    logic signed [31:0] r_vel [3];
    logic signed [31:0] r_spin [3];
    logic signed [31:0] r_trq [3];
    logic signed [31:0] r_ori [4];

    // latched item
    logic [2:0]         r_mode;
    logic               r_gnd;
    logic signed [31:0] r_a [3];
    logic signed [31:0] r_b [3];

    // sequencer
    logic [3:0] r_ph;
    logic [1:0] r_ax;
    logic [1:0] r_sub;
    logic       r_hal;
    logic [4:0] r_cnt;

    // working registers
    logic signed [65:0] r_prod;
    logic signed [66:0] r_acc;
    logic signed [31:0] r_t [3];
    logic signed [31:0] r_tmp;
    logic signed [46:0] r_d [4];
    logic [63:0]        r_s2;
    logic [62:0]        r_n2;
    logic [FRAC_BITS:0] r_fr;

    // root and divider
    logic [62:0] r_sn;
    logic [63:0] r_sr;
    logic [63:0] r_sbit;
    logic [61:0] r_rem;
    logic [61:0] r_dvs;
    logic [30:0] r_q;
    logic        r_neg;

    // output register
    logic               r_ovld;
    logic signed [31:0] r_opos [3];
    logic signed [31:0] r_oori [4];
    logic signed [31:0] r_ovel [3];

    logic signed [32:0] m_a;
    logic signed [32:0] m_b;
    logic               mul_ph;
    logic signed [65:0] pf;
    logic signed [66:0] drv_term;
    logic signed [66:0] dq_val;
    logic signed [66:0] fr_full;
    logic [62:0]        n2_sum;
    logic [63:0]        sq_sum;
    logic               sq_ge;
    logic [63:0]        sr_nx;
    logic               dv_ge;
    logic [30:0]        q_nx;
    logic [31:0]        dv_mag;
    logic signed [31:0] dv_c;

    function automatic logic signed [46:0] clamp_d(input logic signed [66:0] v);
        logic signed [46:0] res;
        if (v > DQ_LIM) begin
            res = DQ_LIM[46:0];
        end else if (v < -DQ_LIM) begin
            res = 47'(-DQ_LIM);
        end else begin
            res = v[46:0];
        end
        return res;
    endfunction

    assign o_stall = (r_ph != rbi_pkg::PH_IDLE);
    assign o_valid = r_ovld;
    assign o_pos_x = r_opos[0];
    assign o_pos_y = r_opos[1];
    assign o_pos_z = r_opos[2];
    assign o_orient_x = r_oori[0];
    assign o_orient_y = r_oori[1];
    assign o_orient_z = r_oori[2];
    assign o_orient_w = r_oori[3];
    assign o_vel_x = r_ovel[0];
    assign o_vel_y = r_ovel[1];
    assign o_vel_z = r_ovel[2];

    // phases that use the multiplier: issue cycle then consume cycle
    assign mul_ph = (r_ph == rbi_pkg::PH_CRS) || (r_ph == rbi_pkg::PH_IMP) ||
                    (r_ph == rbi_pkg::PH_LIN) || (r_ph == rbi_pkg::PH_SSQ) ||
                    (r_ph == rbi_pkg::PH_DRV) || (r_ph == rbi_pkg::PH_DQ)  ||
                    (r_ph == rbi_pkg::PH_NSQ) || (r_ph == rbi_pkg::PH_FRC) ||
                    (r_ph == rbi_pkg::PH_DMP);

    // product floored back to the fixed-point scale
    assign pf       = r_prod >>> FRAC_BITS;
    assign drv_term = ((r_ax == 2'd3) || (r_sub == 2'd2)) ? -67'(pf) : 67'(pf);
    assign dq_val   = (r_acc + 67'(r_prod)) >>> (FRAC_BITS + 1);
    assign fr_full  = ONE_S - 67'(pf);
    assign n2_sum   = r_n2 + 63'(r_prod[63:2]);

    // root step
    assign sq_sum = r_sr + r_sbit;
    assign sq_ge  = 64'(r_sn) >= sq_sum;
    assign sr_nx  = sq_ge ? ((r_sr >> 1) + r_sbit) : (r_sr >> 1);

    // divide step
    assign dv_ge  = r_rem >= r_dvs;
    assign q_nx   = {r_q[29:0], dv_ge};
    assign dv_c   = r_ori[r_ax];
    assign dv_mag = dv_c[31] ? 32'(-dv_c) : 32'(dv_c);

    // multiplier operand select
    always_comb begin
        m_a = '0;
        m_b = '0;
        unique case (r_ph)
            rbi_pkg::PH_CRS: begin
                unique case ({r_ax, r_sub[0]})
                    3'd0: begin m_a = 33'(r_b[1]); m_b = 33'(r_a[2]); end
                    3'd1: begin m_a = 33'(r_b[2]); m_b = 33'(r_a[1]); end
                    3'd2: begin m_a = 33'(r_b[2]); m_b = 33'(r_a[0]); end
                    3'd3: begin m_a = 33'(r_b[0]); m_b = 33'(r_a[2]); end
                    3'd4: begin m_a = 33'(r_b[0]); m_b = 33'(r_a[1]); end
                    3'd5: begin m_a = 33'(r_b[1]); m_b = 33'(r_a[0]); end
                    default: begin m_a = '0; m_b = '0; end
                endcase
            end
            rbi_pkg::PH_IMP: begin
                if (r_sub == 2'd0) begin
                    m_a = 33'(r_a[r_ax]);
                    m_b = $signed(33'(r_imas));
                end else begin
                    m_a = 33'(r_t[r_ax]);
                    m_b = $signed(33'(r_iinv[r_ax]));
                end
            end
            rbi_pkg::PH_LIN: begin
                unique case (r_sub)
                    2'd0: begin m_a = 33'(r_a[r_ax]);   m_b = $signed(33'(r_ts)); end
                    2'd1: begin m_a = 33'(r_vel[r_ax]); m_b = $signed(33'(r_ts)); end
                    2'd2: begin
                        m_a = 33'(r_trq[r_ax]);
                        m_b = $signed(33'(r_iinv[r_ax]));
                    end
                    2'd3: begin m_a = 33'(r_tmp); m_b = $signed(33'(r_ts)); end
                    default: begin m_a = '0; m_b = '0; end
                endcase
            end
            rbi_pkg::PH_SSQ: begin
                m_a = 33'(r_spin[r_ax]);
                m_b = 33'(r_spin[r_ax]);
            end
            rbi_pkg::PH_DRV: begin
                // Hamilton product terms of spin (x) q
                unique case ({r_ax, r_sub})
                    4'd0:  begin m_a = 33'(r_spin[0]); m_b = 33'(r_ori[3]); end
                    4'd1:  begin m_a = 33'(r_spin[1]); m_b = 33'(r_ori[2]); end
                    4'd2:  begin m_a = 33'(r_spin[2]); m_b = 33'(r_ori[1]); end
                    4'd4:  begin m_a = 33'(r_spin[1]); m_b = 33'(r_ori[3]); end
                    4'd5:  begin m_a = 33'(r_spin[2]); m_b = 33'(r_ori[0]); end
                    4'd6:  begin m_a = 33'(r_spin[0]); m_b = 33'(r_ori[2]); end
                    4'd8:  begin m_a = 33'(r_spin[2]); m_b = 33'(r_ori[3]); end
                    4'd9:  begin m_a = 33'(r_spin[0]); m_b = 33'(r_ori[1]); end
                    4'd10: begin m_a = 33'(r_spin[1]); m_b = 33'(r_ori[0]); end
                    4'd12: begin m_a = 33'(r_spin[0]); m_b = 33'(r_ori[0]); end
                    4'd13: begin m_a = 33'(r_spin[1]); m_b = 33'(r_ori[1]); end
                    4'd14: begin m_a = 33'(r_spin[2]); m_b = 33'(r_ori[2]); end
                    default: begin m_a = '0; m_b = '0; end
                endcase
            end
            rbi_pkg::PH_DQ: begin
                // clamped delta split into high and low halves
                if (r_sub == 2'd0) begin
                    m_a = 33'($signed(r_d[r_ax][46:24]));
                end else begin
                    m_a = $signed(33'(r_d[r_ax][23:0]));
                end
                m_b = $signed(33'(r_ts));
            end
            rbi_pkg::PH_NSQ: begin
                m_a = 33'(r_ori[r_ax]);
                m_b = 33'(r_ori[r_ax]);
            end
            rbi_pkg::PH_FRC: begin
                m_a = $signed(33'(r_fric));
                m_b = $signed(33'(r_ts));
            end
            rbi_pkg::PH_DMP: begin
                if (r_sub == 2'd0) begin
                    m_a = 33'(r_vel[r_ax]);
                    m_b = $signed(33'(r_fr));
                end else begin
                    m_a = 33'(r_spin[r_ax]);
                    m_b = DAMP;
                end
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    // sequencer, state and config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dyn  <= 1'b1;
            r_imas <= ONE_U;
            for (int i = 0; i < 3; i++) begin
                r_iinv[i] <= ONE_U;
                r_pos[i]  <= '0;
                r_vel[i]  <= '0;
                r_spin[i] <= '0;
                r_trq[i]  <= '0;
                r_ori[i]  <= '0;
            end
            r_ori[3] <= rbi_pkg::QUAT_ONE;
            r_fric   <= FRIC_RST;
            r_ts     <= TS_RST;
            r_ph     <= rbi_pkg::PH_IDLE;
            r_ax     <= '0;
            r_sub    <= '0;
            r_hal    <= 1'b0;
            r_cnt    <= '0;
            r_ovld   <= 1'b0;
        end else begin
            // config writes
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    rbi_pkg::CFG_DYN:  r_dyn     <= i_cfg_data[0];
                    rbi_pkg::CFG_IMAS: r_imas    <= i_cfg_data;
                    rbi_pkg::CFG_IIX:  r_iinv[0] <= i_cfg_data;
                    rbi_pkg::CFG_IIY:  r_iinv[1] <= i_cfg_data;
                    rbi_pkg::CFG_IIZ:  r_iinv[2] <= i_cfg_data;
                    rbi_pkg::CFG_FRIC: r_fric    <= i_cfg_data[16:0];
                    rbi_pkg::CFG_TS:   r_ts      <= i_cfg_data[16:0];
                    default: ;
                endcase
            end

            // result taken; the final phase reloads it on its own
            if (r_ovld && !i_stall && (r_ph != rbi_pkg::PH_FIN)) begin
                r_ovld <= 1'b0;
            end

            // shared multiplier
            if (mul_ph) begin
                r_hal <= !r_hal;
                if (!r_hal) begin
                    r_prod <= 66'(m_a) * 66'(m_b);
                end
            end

            unique case (r_ph)
                rbi_pkg::PH_IDLE: begin
                    if (i_valid) begin
                        r_mode <= i_mode;
                        r_gnd  <= i_on_ground;
                        r_a[0] <= i_vec_a_x;
                        r_a[1] <= i_vec_a_y;
                        r_a[2] <= i_vec_a_z;
                        r_ax   <= '0;
                        r_sub  <= '0;
                        r_hal  <= 1'b0;
                        priority if (i_mode == rbi_pkg::MODE_SET_XF ||
                                     i_mode == rbi_pkg::MODE_SET_ORI) begin
                            if (i_mode == rbi_pkg::MODE_SET_XF) begin
                                r_pos[0] <= i_vec_a_x;
                                r_pos[1] <= i_vec_a_y;
                                r_pos[2] <= i_vec_a_z;
                            end
                            r_ori[0] <= i_vec_b_x;
                            r_ori[1] <= i_vec_b_y;
                            r_ori[2] <= i_vec_b_z;
                            r_ori[3] <= i_quat_w;
                            r_ph     <= rbi_pkg::PH_FIN;
                        end else if (r_dyn && i_mode == rbi_pkg::MODE_IMPULSE) begin
                            r_b[0] <= i_vec_b_x;
                            r_b[1] <= i_vec_b_y;
                            r_b[2] <= i_vec_b_z;
                            r_ph   <= rbi_pkg::PH_CRS;
                        end else if (r_dyn && i_mode == rbi_pkg::MODE_FORCE) begin
                            // lever arm from the body position
                            r_b[0] <= rbi_pkg::sat32(72'(i_vec_b_x) - 72'(r_pos[0]));
                            r_b[1] <= rbi_pkg::sat32(72'(i_vec_b_y) - 72'(r_pos[1]));
                            r_b[2] <= rbi_pkg::sat32(72'(i_vec_b_z) - 72'(r_pos[2]));
                            r_ph   <= rbi_pkg::PH_CRS;
                        end else if (r_dyn && i_mode == rbi_pkg::MODE_INTEG) begin
                            r_s2 <= '0;
                            r_ph <= rbi_pkg::PH_LIN;
                        end else begin
                            r_ph <= rbi_pkg::PH_FIN;
                        end
                    end
                end

                // cross product b x a, one component per axis
                rbi_pkg::PH_CRS: begin
                    if (r_hal) begin
                        if (r_sub == 2'd0) begin
                            r_acc <= 67'(pf);
                            r_sub <= 2'd1;
                        end else begin
                            r_t[r_ax] <= rbi_pkg::sat32(72'(r_acc) - 72'(pf));
                            r_sub     <= 2'd0;
                            if (r_ax == 2'd2) begin
                                r_ax <= '0;
                                r_ph <= (r_mode == rbi_pkg::MODE_IMPULSE) ?
                                        rbi_pkg::PH_IMP : rbi_pkg::PH_TRQ;
                            end else begin
                                r_ax <= r_ax + 2'd1;
                            end
                        end
                    end
                end

                rbi_pkg::PH_IMP: begin
                    if (r_hal) begin
                        if (r_sub == 2'd0) begin
                            r_vel[r_ax] <= rbi_pkg::sat32(72'(r_vel[r_ax]) + 72'(pf));
                            r_sub       <= 2'd1;
                        end else begin
                            r_spin[r_ax] <= rbi_pkg::sat32(72'(r_spin[r_ax]) + 72'(pf));
                            r_sub        <= 2'd0;
                            if (r_ax == 2'd2) begin
                                r_ax <= '0;
                                r_ph <= rbi_pkg::PH_FIN;
                            end else begin
                                r_ax <= r_ax + 2'd1;
                            end
                        end
                    end
                end

                rbi_pkg::PH_TRQ: begin
                    for (int i = 0; i < 3; i++) begin
                        r_trq[i] <= rbi_pkg::sat32(72'(r_trq[i]) + 72'(r_t[i]));
                    end
                    r_ph <= rbi_pkg::PH_FIN;
                end

                // gravity, position, torque to spin per axis
                rbi_pkg::PH_LIN: begin
                    if (r_hal) begin
                        unique case (r_sub)
                            2'd0: begin
                                if (!r_gnd) begin
                                    r_vel[r_ax] <= rbi_pkg::sat32(72'(r_vel[r_ax]) + 72'(pf));
                                end
                            end
                            2'd1: r_pos[r_ax] <= rbi_pkg::sat32(72'(r_pos[r_ax]) + 72'(pf));
                            2'd2: r_tmp <= rbi_pkg::sat32(72'(pf));
                            2'd3: r_spin[r_ax] <= rbi_pkg::sat32(72'(r_spin[r_ax]) + 72'(pf));
                            default: ;
                        endcase
                        r_sub <= r_sub + 2'd1;
                        if (r_sub == 2'd3) begin
                            if (r_ax == 2'd2) begin
                                r_ax <= '0;
                                r_ph <= rbi_pkg::PH_SSQ;
                            end else begin
                                r_ax <= r_ax + 2'd1;
                            end
                        end
                    end
                end

                rbi_pkg::PH_SSQ: begin
                    if (r_hal) begin
                        r_s2 <= r_s2 + r_prod[63:0];
                        if (r_ax == 2'd2) begin
                            r_ax <= '0;
                            r_ph <= rbi_pkg::PH_CHK;
                        end else begin
                            r_ax <= r_ax + 2'd1;
                        end
                    end
                end

                rbi_pkg::PH_CHK: begin
                    r_ax  <= '0;
                    r_sub <= '0;
                    r_ph  <= (r_s2 > SPIN_EPS) ? rbi_pkg::PH_DRV : rbi_pkg::PH_FRC;
                end

                // quaternion derivative, three terms per component
                rbi_pkg::PH_DRV: begin
                    if (r_hal) begin
                        unique case (r_sub)
                            2'd0: begin
                                r_acc <= drv_term;
                                r_sub <= 2'd1;
                            end
                            2'd1: begin
                                r_acc <= r_acc + drv_term;
                                r_sub <= 2'd2;
                            end
                            default: begin
                                r_d[r_ax] <= clamp_d(r_acc + drv_term);
                                r_sub     <= 2'd0;
                                if (r_ax == 2'd3) begin
                                    r_ax <= '0;
                                    r_ph <= rbi_pkg::PH_DQ;
                                end else begin
                                    r_ax <= r_ax + 2'd1;
                                end
                            end
                        endcase
                    end
                end

                // delta times dt, applied to each component
                rbi_pkg::PH_DQ: begin
                    if (r_hal) begin
                        if (r_sub == 2'd0) begin
                            r_acc <= 67'(r_prod) <<< 24;
                            r_sub <= 2'd1;
                        end else begin
                            r_ori[r_ax] <= rbi_pkg::sat32(72'(r_ori[r_ax]) + 72'(dq_val));
                            r_sub       <= 2'd0;
                            if (r_ax == 2'd3) begin
                                r_ax <= '0;
                                r_n2 <= '0;
                                r_ph <= rbi_pkg::PH_NSQ;
                            end else begin
                                r_ax <= r_ax + 2'd1;
                            end
                        end
                    end
                end

                rbi_pkg::PH_NSQ: begin
                    if (r_hal) begin
                        r_n2 <= n2_sum;
                        if (r_ax == 2'd3) begin
                            r_ax   <= '0;
                            r_sn   <= n2_sum;
                            r_sr   <= '0;
                            r_sbit <= 64'd1 << 62;
                            r_ph   <= rbi_pkg::PH_SQRT;
                        end else begin
                            r_ax <= r_ax + 2'd1;
                        end
                    end
                end

                // integer root, one result bit per cycle
                rbi_pkg::PH_SQRT: begin
                    if (sq_ge) begin
                        r_sn <= 63'(64'(r_sn) - sq_sum);
                    end
                    r_sr   <= sr_nx;
                    r_sbit <= r_sbit >> 2;
                    if (r_sbit[0]) begin
                        r_sub <= '0;
                        r_ph  <= (sr_nx == 64'd0) ? rbi_pkg::PH_FRC : rbi_pkg::PH_DIV;
                    end
                end

                // restoring divide: component * 2^29 / norm
                rbi_pkg::PH_DIV: begin
                    if (r_sub == 2'd0) begin
                        r_neg <= dv_c[31];
                        if (34'(dv_mag) >= {r_sr[31:0], 2'b00}) begin
                            r_ori[r_ax] <= dv_c[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                            if (r_ax == 2'd3) begin
                                r_ax <= '0;
                                r_ph <= rbi_pkg::PH_FRC;
                            end else begin
                                r_ax <= r_ax + 2'd1;
                            end
                        end else begin
                            r_rem <= 62'(dv_mag) << 29;
                            r_dvs <= 62'(r_sr[31:0]) << 30;
                            r_q   <= '0;
                            r_cnt <= 5'd30;
                            r_sub <= 2'd1;
                        end
                    end else begin
                        if (dv_ge) begin
                            r_rem <= r_rem - r_dvs;
                        end
                        r_dvs <= r_dvs >> 1;
                        r_q   <= q_nx;
                        r_cnt <= r_cnt - 5'd1;
                        if (r_cnt == 5'd0) begin
                            r_ori[r_ax] <= r_neg ? -$signed({1'b0, q_nx}) : $signed({1'b0, q_nx});
                            r_sub       <= 2'd0;
                            if (r_ax == 2'd3) begin
                                r_ax <= '0;
                                r_ph <= rbi_pkg::PH_FRC;
                            end else begin
                                r_ax <= r_ax + 2'd1;
                            end
                        end
                    end
                end

                // friction factor, clamped at zero
                rbi_pkg::PH_FRC: begin
                    if (r_hal) begin
                        r_fr  <= fr_full[66] ? '0 : fr_full[FRAC_BITS:0];
                        r_ax  <= '0;
                        r_sub <= '0;
                        r_ph  <= rbi_pkg::PH_DMP;
                    end
                end

                rbi_pkg::PH_DMP: begin
                    if (r_hal) begin
                        if (r_sub == 2'd0) begin
                            r_vel[r_ax] <= rbi_pkg::sat32(72'(pf));
                            r_sub       <= 2'd1;
                        end else begin
                            r_spin[r_ax] <= rbi_pkg::sat32(72'(pf));
                            r_sub        <= 2'd0;
                            if (r_ax == 2'd2) begin
                                r_ax <= '0;
                                for (int i = 0; i < 3; i++) begin
                                    r_trq[i] <= '0;
                                end
                                r_ph <= rbi_pkg::PH_FIN;
                            end else begin
                                r_ax <= r_ax + 2'd1;
                            end
                        end
                    end
                end

                // hand the state to the output register once it is free
                rbi_pkg::PH_FIN: begin
                    if (!r_ovld || !i_stall) begin
                        for (int i = 0; i < 3; i++) begin
                            r_opos[i] <= r_pos[i];
                            r_ovel[i] <= r_vel[i];
                        end
                        for (int i = 0; i < 4; i++) begin
                            r_oori[i] <= r_ori[i];
                        end
                        r_ovld <= 1'b1;
                        r_ph   <= rbi_pkg::PH_IDLE;
                    end
                end

                default: r_ph <= rbi_pkg::PH_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== test/rbi_checker.sv =====
// Scoreboard for the rigid body integrator: mirrors config writes, predicts
// the body state after each accepted item and compares each result. Uses rbi_pkg.
module rbi_checker #(
    parameter int FRAC_BITS = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire  [2:0]          i_cfg_idx,
    input  wire  [30:0]         i_cfg_data,
    input  wire                 i_valid,
    input  wire                 i_in_stall,
    input  wire  [2:0]          i_mode,
    input  wire  signed [31:0]  i_a_x,
    input  wire  signed [31:0]  i_a_y,
    input  wire  signed [31:0]  i_a_z,
    input  wire  signed [31:0]  i_b_x,
    input  wire  signed [31:0]  i_b_y,
    input  wire  signed [31:0]  i_b_z,
    input  wire  signed [31:0]  i_qw,
    input  wire                 i_on_ground,
    input  wire                 i_res_valid,
    input  wire                 i_res_stall,
    input  wire  [319:0]        i_res,
    output int                  o_errors,
    output int                  o_pending,
    output int                  o_results
);
    import rbi_pkg::*;

    typedef logic signed [63:0] t_wide;

    localparam t_wide ONE_FX   = t_wide'(1) <<< FRAC_BITS;
    localparam t_wide DAMP     = ((t_wide'(98) <<< FRAC_BITS) + 50) / 100;
    localparam t_wide SPIN_EPS = (t_wide'(1) <<< (2 * FRAC_BITS)) / 1000000;
    localparam t_wide DQ_LIM   = t_wide'(1) <<< 45;

    logic        dyn_en;
    t_wide       imass, fric, dt;
    t_wide       iinert [3];
    t_word       pos [3], vel [3], spn [3], ori [4], trq [3];
    logic [319:0] state_q [$];

    function automatic t_word sat(input t_wide v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // floor product of two values, shifted
    function automatic t_wide fmul(input t_wide a, input t_wide b, input int s);
        return (a * b) >>> s;
    endfunction

    function automatic t_wide clamp_dq(input t_wide v);
        if (v > DQ_LIM) return DQ_LIM;
        if (v < -DQ_LIM) return -DQ_LIM;
        return v;
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] n);
        logic [63:0] r, bit_v;
        r = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > n) bit_v = bit_v >> 2;
        while (bit_v != 0) begin
            if (n >= r + bit_v) begin
                n = n - (r + bit_v);
                r = (r >> 1) + bit_v;
            end else begin
                r = r >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return r;
    endfunction

    task automatic cross_fx(input t_word a[3], input t_word b[3], output t_word o[3]);
        o[0] = sat(fmul(a[1], b[2], FRAC_BITS) - fmul(a[2], b[1], FRAC_BITS));
        o[1] = sat(fmul(a[2], b[0], FRAC_BITS) - fmul(a[0], b[2], FRAC_BITS));
        o[2] = sat(fmul(a[0], b[1], FRAC_BITS) - fmul(a[1], b[0], FRAC_BITS));
    endtask

    // quaternion rotate by spin, then renormalize
    task automatic spin_orientation();
        t_wide d [4];
        t_word c [4];
        logic [63:0] n2, nrm;
        t_wide p;
        n2 = 0;
        d[0] = fmul(spn[0], ori[3], FRAC_BITS) + fmul(spn[1], ori[2], FRAC_BITS)
             - fmul(spn[2], ori[1], FRAC_BITS);
        d[1] = fmul(spn[1], ori[3], FRAC_BITS) + fmul(spn[2], ori[0], FRAC_BITS)
             - fmul(spn[0], ori[2], FRAC_BITS);
        d[2] = fmul(spn[2], ori[3], FRAC_BITS) + fmul(spn[0], ori[1], FRAC_BITS)
             - fmul(spn[1], ori[0], FRAC_BITS);
        d[3] = -(fmul(spn[0], ori[0], FRAC_BITS) + fmul(spn[1], ori[1], FRAC_BITS)
             + fmul(spn[2], ori[2], FRAC_BITS));
        for (int i = 0; i < 4; i++) begin
            c[i] = sat(t_wide'(ori[i]) + fmul(clamp_dq(d[i]), dt, FRAC_BITS + 1));
            p = t_wide'(c[i]) * t_wide'(c[i]);
            n2 = n2 + (64'(p) >> 2);
        end
        nrm = root64(n2);
        for (int i = 0; i < 4; i++) begin
            if (nrm == 0) ori[i] = c[i];
            else ori[i] = sat((t_wide'(c[i]) <<< 29) / t_wide'(nrm));
        end
    endtask

    task automatic step_body(input t_word a[3], input logic grounded);
        t_wide fr;
        t_word acc;
        logic [63:0] s2;
        s2 = 0;
        for (int i = 0; i < 3; i++) begin
            if (!grounded) vel[i] = sat(t_wide'(vel[i]) + fmul(a[i], dt, FRAC_BITS));
            pos[i] = sat(t_wide'(pos[i]) + fmul(vel[i], dt, FRAC_BITS));
            acc = sat(fmul(trq[i], iinert[i], FRAC_BITS));
            spn[i] = sat(t_wide'(spn[i]) + fmul(acc, dt, FRAC_BITS));
            s2 = s2 + 64'(t_wide'(spn[i]) * t_wide'(spn[i]));
        end
        if (s2 > 64'(SPIN_EPS)) spin_orientation();
        fr = ONE_FX - fmul(fric, dt, FRAC_BITS);
        if (fr < 0) fr = 0;
        for (int i = 0; i < 3; i++) begin
            vel[i] = sat(fmul(vel[i], fr, FRAC_BITS));
            spn[i] = sat(fmul(spn[i], DAMP, FRAC_BITS));
            trq[i] = 0;
        end
    endtask

    task automatic apply_item();
        t_word a [3], b [3], t [3], r [3];
        a = '{i_a_x, i_a_y, i_a_z};
        b = '{i_b_x, i_b_y, i_b_z};
        if (i_mode == MODE_IMPULSE && dyn_en) begin
            cross_fx(b, a, t);
            for (int i = 0; i < 3; i++) begin
                vel[i] = sat(t_wide'(vel[i]) + fmul(a[i], imass, FRAC_BITS));
                spn[i] = sat(t_wide'(spn[i]) + fmul(t[i], iinert[i], FRAC_BITS));
            end
        end else if (i_mode == MODE_FORCE && dyn_en) begin
            for (int i = 0; i < 3; i++) r[i] = sat(t_wide'(b[i]) - t_wide'(pos[i]));
            cross_fx(r, a, t);
            for (int i = 0; i < 3; i++) trq[i] = sat(t_wide'(trq[i]) + t_wide'(t[i]));
        end else if (i_mode == MODE_INTEG && dyn_en) begin
            step_body(a, i_on_ground);
        end else if (i_mode == MODE_SET_XF || i_mode == MODE_SET_ORI) begin
            for (int i = 0; i < 3; i++) begin
                if (i_mode == MODE_SET_XF) pos[i] = a[i];
                ori[i] = b[i];
            end
            ori[3] = i_qw;
        end
        state_q.push_back({pos[0], pos[1], pos[2], ori[0], ori[1], ori[2], ori[3],
                           vel[0], vel[1], vel[2]});
    endtask

    task automatic compare_result();
        logic [319:0] exp_v;
        string names [10];
        names = '{"pos_x", "pos_y", "pos_z", "orient_x", "orient_y", "orient_z",
                  "orient_w", "vel_x", "vel_y", "vel_z"};
        if (state_q.size() == 0) begin
            $error("result with no item outstanding");
            o_errors++;
            return;
        end
        exp_v = state_q.pop_front();
        for (int f = 0; f < 10; f++) begin
            if (exp_v[319 - 32*f -: 32] !== i_res[319 - 32*f -: 32]) begin
                $error("%s: expected %0d actual %0d", names[f],
                       $signed(exp_v[319 - 32*f -: 32]), $signed(i_res[319 - 32*f -: 32]));
                o_errors++;
            end
        end
    endtask

    initial begin
        o_errors = 0;
        o_results = 0;
    end

    assign o_pending = state_q.size();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dyn_en = 1'b1;
            imass = ONE_FX;
            fric = (ONE_FX + 5) / 10;
            dt = ONE_FX / 60;
            for (int i = 0; i < 3; i++) begin
                iinert[i] = ONE_FX;
                pos[i] = 0; vel[i] = 0; spn[i] = 0; trq[i] = 0; ori[i] = 0;
            end
            ori[3] = QUAT_ONE;
        end else begin
            // results first; the prediction queue keeps item order, so order is safe
            if (i_res_valid && !i_res_stall) begin
                compare_result();
                o_results++;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DYN:  dyn_en = i_cfg_data[0];
                    CFG_IMAS: imass = t_wide'(i_cfg_data);
                    CFG_IIX:  iinert[0] = t_wide'(i_cfg_data);
                    CFG_IIY:  iinert[1] = t_wide'(i_cfg_data);
                    CFG_IIZ:  iinert[2] = t_wide'(i_cfg_data);
                    CFG_FRIC: fric = t_wide'(i_cfg_data[16:0]);
                    CFG_TS:   dt = t_wide'(i_cfg_data[16:0]);
                    default: ;
                endcase
            end
            if (i_valid && !i_in_stall) apply_item();
        end
    end
endmodule

// ===== test/tb_top.sv =====
// Testbench top for the rigid body integrator: clock, reset, config phases,
// directed and random items with idle and stall patterns. Uses rbi_pkg, rbi_checker, rigid_body_integrator.
module tb_top;

    logic        i_clk, i_rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [30:0] cfg_data;
    logic        in_valid, in_stall;
    logic [2:0]  mode;
    logic signed [31:0] a_x, a_y, a_z, b_x, b_y, b_z, qw;
    logic        on_ground;
    logic        res_valid, res_stall;
    logic signed [31:0] p_x, p_y, p_z, q_x, q_y, q_z, q_w, v_x, v_y, v_z;
    int          errors, pending, results, n_items;
    int          send_idle, recv_stall;

    rigid_body_integrator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .o_stall(in_stall), .i_mode(mode),
        .i_vec_a_x(a_x), .i_vec_a_y(a_y), .i_vec_a_z(a_z),
        .i_vec_b_x(b_x), .i_vec_b_y(b_y), .i_vec_b_z(b_z),
        .i_quat_w(qw), .i_on_ground(on_ground),
        .o_valid(res_valid), .i_stall(res_stall),
        .o_pos_x(p_x), .o_pos_y(p_y), .o_pos_z(p_z),
        .o_orient_x(q_x), .o_orient_y(q_y), .o_orient_z(q_z), .o_orient_w(q_w),
        .o_vel_x(v_x), .o_vel_y(v_y), .o_vel_z(v_z)
    );

    rbi_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .i_in_stall(in_stall), .i_mode(mode),
        .i_a_x(a_x), .i_a_y(a_y), .i_a_z(a_z),
        .i_b_x(b_x), .i_b_y(b_y), .i_b_z(b_z), .i_qw(qw), .i_on_ground(on_ground),
        .i_res_valid(res_valid), .i_res_stall(res_stall),
        .i_res({p_x, p_y, p_z, q_x, q_y, q_z, q_w, v_x, v_y, v_z}),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // receiver stall, percentage set by the phase
    always @(posedge i_clk) begin
        res_stall <= ($urandom_range(99) < recv_stall);
    end

    // one write, with the write enable dropped again before the next
    task automatic write_reg(input logic [2:0] idx, input logic [30:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // drop valid, drain all results, then let a rotating integrate settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    // valid stays high after acceptance until the next call or wait_idle
    task automatic send_item(input logic [2:0] m, input logic signed [31:0] ax, ay, az,
                             input logic signed [31:0] bx, by, bz, w, input logic g);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        a_x <= ax; a_y <= ay; a_z <= az;
        b_x <= bx; b_y <= by; b_z <= bz;
        qw <= w; on_ground <= g;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        n_items++;
    endtask

    // vector values: mostly moderate, some full range
    function automatic logic signed [31:0] rnd_vec();
        case ($urandom_range(9))
            0: return $urandom;
            1: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            2, 3: return $signed($urandom_range(2000000)) - 1000000;
            default: return $signed($urandom_range(400000)) - 200000;
        endcase
    endfunction

    function automatic logic signed [31:0] rnd_quat();
        if ($urandom_range(9) == 0) return $urandom;
        return $signed($urandom_range(32'h8000_0000)) - 32'sh4000_0000;
    endfunction

    task automatic random_item();
        logic [2:0] m;
        int r;
        r = $urandom_range(99);
        if (r < 30) m = rbi_pkg::MODE_IMPULSE;
        else if (r < 55) m = rbi_pkg::MODE_FORCE;
        else if (r < 85) m = rbi_pkg::MODE_INTEG;
        else if (r < 91) m = rbi_pkg::MODE_SET_XF;
        else if (r < 97) m = rbi_pkg::MODE_SET_ORI;
        else m = 3'($urandom_range(5, 7));
        send_item(m, rnd_vec(), rnd_vec(), rnd_vec(),
                  (m >= rbi_pkg::MODE_SET_XF) ? rnd_quat() : rnd_vec(),
                  (m >= rbi_pkg::MODE_SET_XF) ? rnd_quat() : rnd_vec(),
                  (m >= rbi_pkg::MODE_SET_XF) ? rnd_quat() : rnd_vec(),
                  $urandom, $urandom_range(1));
    endtask

    task automatic random_config();
        write_reg(rbi_pkg::CFG_DYN, ($urandom_range(9) == 0) ? 31'd0 : 31'd1);
        write_reg(rbi_pkg::CFG_IMAS, ($urandom_range(5) == 0) ? 31'($urandom)
                                                             : 31'($urandom_range(262144)));
        write_reg(rbi_pkg::CFG_IIX, ($urandom_range(5) == 0) ? 31'($urandom)
                                                            : 31'($urandom_range(262144)));
        write_reg(rbi_pkg::CFG_IIY, 31'($urandom_range(262144)));
        write_reg(rbi_pkg::CFG_IIZ, 31'($urandom_range(262144)));
        write_reg(rbi_pkg::CFG_FRIC, 31'($urandom_range(65536)));
        write_reg(rbi_pkg::CFG_TS, ($urandom_range(3) == 0) ? 31'($urandom_range(65536))
                                                           : 31'($urandom_range(4096)));
    endtask

    initial begin
        int idle_tab [4];
        int stall_tab [4];
        idle_tab = '{0, 48, 0, 36};
        stall_tab = '{0, 0, 48, 36};
        i_rst_n = 1'b0;
        cfg_we = 1'b0; cfg_idx = '0; cfg_data = '0;
        in_valid = 1'b0; mode = '0;
        a_x = 0; a_y = 0; a_z = 0; b_x = 0; b_y = 0; b_z = 0; qw = 0;
        on_ground = 1'b0; res_stall = 1'b0;
        send_idle = 0; recv_stall = 0; n_items = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every mode at reset config, extremes and special cases
        send_item(rbi_pkg::MODE_IMPULSE, 32'sh0001_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                  32'sh7FFF_FFFF, 32'sh0002_0000, 32'sh8000_0000, 0, 0);
        send_item(rbi_pkg::MODE_FORCE, 32'sh7FFF_FFFF, 32'sh0001_0000, 32'sh8000_0000,
                  32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_8000, 0, 1);
        send_item(rbi_pkg::MODE_INTEG, 0, 32'shFFF6_0000, 0, 0, 0, 0, 0, 0);
        send_item(rbi_pkg::MODE_INTEG, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                  0, 0, 0, 0, 1);
        send_item(rbi_pkg::MODE_SET_XF, 32'sh8000_0000, 32'sh7FFF_FFFF, -1,
                  0, 0, 0, 0, 0);                       // zero quaternion
        send_item(rbi_pkg::MODE_IMPULSE, 0, 0, 32'sh0010_0000, 32'sh0010_0000, 0, 0, 0, 0);
        send_item(rbi_pkg::MODE_INTEG, 0, 0, 0, 0, 0, 0, 0, 1);  // rotate a zero-norm quaternion
        send_item(rbi_pkg::MODE_SET_ORI, -1, -1, -1, 32'sh7FFF_FFFF, 32'sh8000_0000,
                  32'sh7FFF_FFFF, 32'sh8000_0000, 1);
        send_item(rbi_pkg::MODE_INTEG, 0, 0, 0, 0, 0, 0, 0, 1);
        send_item(3'd5, -1, -1, -1, -1, -1, -1, -1, 1);
        send_item(3'd7, 0, 0, 0, 0, 0, 0, 0, 0);
        wait_idle();

        // extreme settings: dynamics off, then maximum gains, then zero gains
        write_reg(rbi_pkg::CFG_DYN, 31'd0);
        send_item(rbi_pkg::MODE_IMPULSE, 32'sh0100_0000, 1, 2, 3, 4, 5, 6, 0);
        send_item(rbi_pkg::MODE_FORCE, 32'sh0100_0000, 1, 2, 3, 4, 5, 6, 0);
        send_item(rbi_pkg::MODE_INTEG, 32'sh0100_0000, 1, 2, 3, 4, 5, 6, 0);
        send_item(rbi_pkg::MODE_SET_XF, 7, 8, 9, 0, 0, 0, rbi_pkg::QUAT_ONE, 0);
        wait_idle();
        write_reg(rbi_pkg::CFG_DYN, 31'd1);
        write_reg(rbi_pkg::CFG_IMAS, 31'h7FFF_FFFF);
        write_reg(rbi_pkg::CFG_IIX, 31'h7FFF_FFFF);
        write_reg(rbi_pkg::CFG_IIY, 31'h7FFF_FFFF);
        write_reg(rbi_pkg::CFG_IIZ, 31'h7FFF_FFFF);
        write_reg(rbi_pkg::CFG_FRIC, 31'd65536);
        write_reg(rbi_pkg::CFG_TS, 31'd65536);          // friction factor hits zero
        send_item(rbi_pkg::MODE_IMPULSE, 32'sh0001_0000, -32'sh0003_0000, 32'sh0000_4000,
                  32'sh0002_0000, 32'sh0001_0000, -32'sh0001_0000, 0, 0);
        send_item(rbi_pkg::MODE_FORCE, 32'sh0001_0000, 32'sh0001_0000, 0, 0, 0,
                  32'sh0001_0000, 0, 0);
        send_item(rbi_pkg::MODE_INTEG, 32'sh0001_0000, 0, 0, 0, 0, 0, 0, 0);
        wait_idle();
        write_reg(rbi_pkg::CFG_IMAS, 31'd0);
        write_reg(rbi_pkg::CFG_IIX, 31'd0);
        write_reg(rbi_pkg::CFG_IIY, 31'd0);
        write_reg(rbi_pkg::CFG_IIZ, 31'd0);
        write_reg(rbi_pkg::CFG_FRIC, 31'd0);
        write_reg(rbi_pkg::CFG_TS, 31'd0);
        send_item(rbi_pkg::MODE_IMPULSE, 32'sh7FFF_FFFF, 1, 1, 1, 1, 1, 0, 0);
        send_item(rbi_pkg::MODE_INTEG, 32'sh7FFF_FFFF, 0, 0, 0, 0, 0, 0, 0);
        wait_idle();

        // random phases, each with a fresh config and idle pattern
        for (int ph = 0; ph < 8; ph++) begin
            random_config();
            send_idle = idle_tab[ph % 4];
            recv_stall = stall_tab[ph % 4];
            for (int k = 0; k < 175; k++) random_item();
            wait_idle();
        end
        send_idle = 0;
        recv_stall = 0;
        wait_idle();

        $display("Covered %0d items, %0d results, all modes over 8 random config phases.",
                 n_items, results);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #(20 * 2000000);
        $display("CHECK FAILED");
        $finish;
    end
endmodule
